// ===== sv/rqk_pkg.sv =====
// ----------------------------------------------------------------------------
// rqk_pkg
// Shared widths, operation and status codes, and the command and status
// bundles between the controller and the datapath of the ring queue.
// ----------------------------------------------------------------------------
package rqk_pkg;

  localparam int KIND_W = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REM = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic            enq;        // write the input word at the tail
    logic            rd;         // read the head entry and advance the head
    logic            push;       // write the word read last cycle at the tail
    logic            pop;        // the read this cycle removes an item
    logic            out_load;   // load the result registers
    logic [ST_W-1:0] out_status;
    logic            take_word;  // result carries the word read last cycle
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

// ===== sv/rqk_ram.sv =====
// ----------------------------------------------------------------------------
// rqk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module rqk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/rqk_dp.sv =====
// ----------------------------------------------------------------------------
// rqk_dp
// Queue datapath: store, head and tail pointers, item count, write-to-read
// forwarding and the result registers.
// ----------------------------------------------------------------------------
module rqk_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rqk_pkg::cmd_t                   cmd,
  input  logic signed [rqk_pkg::VAL_W-1:0] in_value,
  output rqk_pkg::stat_t                  stat,
  output logic                            out_valid,
  output logic [rqk_pkg::ST_W-1:0]        out_status,
  output logic signed [rqk_pkg::VAL_W-1:0] out_removed,
  output logic [rqk_pkg::OCC_W-1:0]       out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [DATA_WIDTH-1:0] fwd_data_r;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;

  logic                            out_valid_r;
  logic [rqk_pkg::ST_W-1:0]        status_r;
  logic signed [rqk_pkg::VAL_W-1:0] removed_r;
  logic [rqk_pkg::OCC_W-1:0]       occ_r;

  // With a single item held, a rotation reads the entry that the previous
  // rotation step is writing in the same cycle, so that word is forwarded.
  assign word    = fwd_r ? fwd_data_r : rd_data;
  assign wr_en   = cmd.enq | cmd.push;
  assign wr_data = cmd.enq ? DATA_WIDTH'($unsigned(in_value)) : word;
  assign fwd_nxt = wr_en && cmd.rd && (tail_r == head_r);

  rqk_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.rd) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (wr_en) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (cmd.enq) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
    if (cmd.out_load) begin
      status_r  <= cmd.out_status;
      removed_r <= cmd.take_word ? rqk_pkg::VAL_W'($signed(word)) : '0;
      occ_r     <= rqk_pkg::OCC_W'(count_nxt);
    end
  end

  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CW'(DEPTH));
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_removed   = removed_r;
  assign out_occupancy = occ_r;

endmodule

// ===== sv/rqk_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqk_ctrl
// Queue controller: decodes each operation, steps the rotations of a
// remove-kth one per cycle and issues commands to the datapath.
// ----------------------------------------------------------------------------
module rqk_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rqk_pkg::KIND_W-1:0]  in_kind,
  input  logic [rqk_pkg::POS_W-1:0]   in_position,
  input  rqk_pkg::stat_t              stat,
  output rqk_pkg::cmd_t               cmd,
  output logic                        busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [rqk_pkg::POS_W-1:0] rot_r, rot_nxt;
  logic                      pend_r, pend_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    rot_nxt   = rot_r;
    pend_nxt  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_kind)
            rqk_pkg::KIND_ENQ: begin
              cmd.enq        = !stat.full;
              cmd.out_load   = 1'b1;
              cmd.out_status = stat.full ? rqk_pkg::ST_FULL : rqk_pkg::ST_OK;
            end
            rqk_pkg::KIND_DEQ, rqk_pkg::KIND_REM: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = rqk_pkg::ST_EMPTY;
              end else begin
                // Position zero and one both mean no rotation.
                rot_nxt   = (in_kind == rqk_pkg::KIND_REM && in_position > 1)
                          ? in_position - 1'b1 : '0;
                state_nxt = S_RUN;
              end
            end
            default: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = rqk_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RUN: begin
        cmd.rd   = 1'b1;
        cmd.push = pend_r;
        if (rot_r != '0) begin
          rot_nxt  = rot_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_load   = 1'b1;
        cmd.out_status = rqk_pkg::ST_OK;
        cmd.take_word  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rot_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ===== sv/ring_queue_with_kth_removal.sv =====
// ----------------------------------------------------------------------------
// ring_queue_with_kth_removal
// Ring-buffer queue of signed words with enqueue, dequeue and remove-kth.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and its single
// result appears on the out_ ports for exactly one cycle with out_valid high;
// the receiver must take it then, as the block cannot be held off. Enqueue,
// an operation on an empty queue and the unused kind leave busy low and show
// their result in the cycle after the transfer. Dequeue and remove-kth with
// k taken as at least one hold busy through the rotation and done states and
// show the result as busy falls, so no new operation is taken before then:
// each of the k-1 rotations and the final removal use the store's single read
// port once. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module ring_queue_with_kth_removal #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rqk_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [rqk_pkg::VAL_W-1:0]  in_value,
  input  logic [rqk_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [rqk_pkg::ST_W-1:0]          out_status,
  output logic signed [rqk_pkg::VAL_W-1:0]  out_removed,
  output logic [rqk_pkg::OCC_W-1:0]         out_occupancy
);

  rqk_pkg::cmd_t  cmd;
  rqk_pkg::stat_t stat;

  rqk_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_kind     (in_kind),
    .in_position (in_position),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  rqk_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_removed   (out_removed),
    .out_occupancy (out_occupancy)
  );

endmodule
